[design/hslrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hslrgb_pkg
// shared constants, types and helpers for the hsl to rgb converter
// ----------------------------------------------------------------------------
package hslrgb_pkg;

  // q16 fixed point: 1.0 = 65536
  localparam int unsigned QW       = 17;  // unsigned q16 fraction 0..1.0
  localparam int unsigned VW       = 19;  // signed upper/lower/difference values
  localparam int unsigned HW       = 18;  // signed shifted hue before wrap
  localparam int unsigned F6W      = 17;  // six times the ramp fraction
  localparam int unsigned PW       = VW + F6W + 1;  // ramp product
  localparam int unsigned CW       = 21;  // signed channel value

  localparam logic [QW-1:0] Q_ONE    = 17'd65536;
  localparam logic [QW-1:0] Q_HALF   = 17'd32768;
  localparam logic [QW-1:0] Q_THIRD  = 17'd21845;
  localparam logic [QW-1:0] Q_2THIRD = 17'd43691;
  // first hue with 6t >= 1
  localparam logic [QW-1:0] Q_SIXTH  = 17'd10923;

  typedef enum logic [1:0] {
    SEL_RAMP,
    SEL_UPPER,
    SEL_LOWER
  } sel_e;

  // x/255 in q16, rounded: x*65536 = x*255*257 + x, so the remainder term is x/255
  function automatic logic [QW-1:0] to_q16(input logic [7:0] x);
    logic [QW-1:0] q;
    q = {1'b0, x, x} + {16'd0, x[7]};
    return q;
  endfunction

endpackage

[design/hslrgb_chan.sv]
// ----------------------------------------------------------------------------
// hslrgb_chan
// one colour channel: hue wrap, segment select, ramp multiply, byte rounding
// ----------------------------------------------------------------------------
module hslrgb_chan import hslrgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [HW-1:0] t_i,
  input  logic signed [VW-1:0] v1_i,
  input  logic signed [VW-1:0] v2_i,
  input  logic signed [VW-1:0] d_i,
  input  logic                 zero_i,
  input  logic [QW-1:0]        l_i,
  output logic [7:0]           byte_o
);

  localparam logic signed [VW-1:0] ONE_S = 19'sd65536;

  // stage a: wrap and segment select
  logic signed [VW-1:0] t_ext, t_w;
  logic [QW-1:0]        t_u, f;
  logic [F6W-1:0]       f6_d;
  sel_e                 sel_d;

  always_comb begin
    t_ext = {t_i[HW-1], t_i};
    if (t_ext < 0) begin
      t_w = t_ext + ONE_S;
    end else if (t_ext > ONE_S) begin
      t_w = t_ext - ONE_S;
    end else begin
      t_w = t_ext;
    end
    t_u = t_w[QW-1:0];
    if (t_u < Q_SIXTH) begin
      sel_d = SEL_RAMP;
      f     = t_u;
    end else if (t_u < Q_HALF) begin
      sel_d = SEL_UPPER;
      f     = '0;
    end else if (t_u < Q_2THIRD) begin
      sel_d = SEL_RAMP;
      f     = Q_2THIRD - t_u;
    end else begin
      sel_d = SEL_LOWER;
      f     = '0;
    end
    f6_d = (f << 2) + (f << 1);
  end

  sel_e                 sel_a_q, sel_b_q;
  logic [F6W-1:0]       f6_q;
  logic signed [VW-1:0] d_q, v1_a_q, v2_a_q, v1_b_q, v2_b_q;
  logic                 zero_a_q, zero_b_q;
  logic [QW-1:0]        l_a_q, l_b_q;
  logic signed [PW-1:0] prod_q;
  logic signed [CW-1:0] c_d, c_q;
  logic [7:0]           byte_d, byte_q;

  // stage c: round the ramp and pick the channel value
  logic signed [PW-1:0] prod_rnd;
  logic signed [CW-1:0] ramp;

  always_comb begin
    prod_rnd = (prod_q + PW'(32768)) >>> 16;
    ramp     = prod_rnd[CW-1:0];
    case (sel_b_q)
      SEL_RAMP:  c_d = CW'(v1_b_q) + ramp;
      SEL_UPPER: c_d = CW'(v2_b_q);
      SEL_LOWER: c_d = CW'(v1_b_q);
      default:   c_d = CW'(v1_b_q);
    endcase
    if (zero_b_q) begin
      c_d = $signed({4'd0, l_b_q});
    end
  end

  // stage d: scale by 255, round and saturate
  logic signed [CW+8:0] scaled, scaled_rnd;

  always_comb begin
    scaled     = ($signed({c_q[CW-1], c_q}) <<< 8) - (CW+9)'(c_q);
    scaled_rnd = (scaled + (CW+9)'(32768)) >>> 16;
    if (scaled_rnd < 0) begin
      byte_d = 8'd0;
    end else if (scaled_rnd > (CW+9)'(255)) begin
      byte_d = 8'd255;
    end else begin
      byte_d = scaled_rnd[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_a_q  <= sel_d;
      f6_q     <= f6_d;
      d_q      <= d_i;
      v1_a_q   <= v1_i;
      v2_a_q   <= v2_i;
      zero_a_q <= zero_i;
      l_a_q    <= l_i;

      prod_q   <= PW'(d_q) * $signed({1'b0, f6_q});
      sel_b_q  <= sel_a_q;
      v1_b_q   <= v1_a_q;
      v2_b_q   <= v2_a_q;
      zero_b_q <= zero_a_q;
      l_b_q    <= l_a_q;

      c_q      <= c_d;
      byte_q   <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[design/hsl_to_rgb_pixel_converter.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel_converter
// pipelined hsl to rgb conversion, one pixel per clock unless stalled, in q16 fixed point
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  input     in         valid_i / ready_o   hue_i, saturation_i, lightness_i
//  output    out        valid_o / ready_i   red_o, green_o, blue_o
//
//  one request per clock while the pipe advances; each is registered in every stage up to valid_o
//  the rate is set by the single pipeline enable: all five stages move together
//  while the output register is empty or being taken
//  reset clears only the valid bits; payload registers hold whatever they had
//  a stall freezes the whole pipe, so nothing is dropped or repeated
//
module hsl_to_rgb_pixel_converter import hslrgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] lightness_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  localparam int unsigned NSTAGE = 5;

  // pipeline enable: move when the output slot is free or being taken
  logic              adv;
  logic [NSTAGE-1:0] vld_q;

  assign adv     = ~vld_q[NSTAGE-1] | ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q[NSTAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTAGE-2:0], valid_i};
    end
  end

  // stage 1: inputs to q16, lightness times saturation, shifted hues
  logic [QW-1:0]        hq, sq, lq;
  logic [QW-1:0]        s_q, l_q;
  logic [2*QW-1:0]      ls_q;
  logic signed [HW-1:0] t_r_q, t_g_q, t_b_q;
  logic                 zero_q;

  assign hq = to_q16(hue_i);
  assign sq = to_q16(saturation_i);
  assign lq = to_q16(lightness_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q    <= sq;
      l_q    <= lq;
      ls_q   <= lq * sq;
      // red sits a third ahead, blue a third behind
      t_r_q  <= $signed({1'b0, hq}) + $signed({1'b0, Q_THIRD});
      t_g_q  <= $signed({1'b0, hq});
      t_b_q  <= $signed({1'b0, hq}) - $signed({1'b0, Q_THIRD});
      zero_q <= (saturation_i == 8'd0);
    end
  end

  // upper and lower values, shared by the three channels
  logic [2*QW-1:0]      ls_rnd;
  logic signed [VW-1:0] prod, l_s, s_s, v2, v1, d;

  always_comb begin
    ls_rnd = (ls_q + (2*QW)'(32768)) >> 16;
    prod   = $signed(VW'(ls_rnd[QW:0]));
    l_s    = $signed({2'b00, l_q});
    s_s    = $signed({2'b00, s_q});
    if (l_q < Q_HALF) begin
      v2 = l_s + prod;
    end else begin
      v2 = l_s + s_s - prod;
    end
    v1 = (l_s <<< 1) - v2;
    d  = v2 - v1;
  end

  // stages 2 to 5: one lane for each colour
  hslrgb_chan u_red (
    .clk_i  (clk_i),
    .en_i   (adv),
    .t_i    (t_r_q),
    .v1_i   (v1),
    .v2_i   (v2),
    .d_i    (d),
    .zero_i (zero_q),
    .l_i    (l_q),
    .byte_o (red_o)
  );

  hslrgb_chan u_green (
    .clk_i  (clk_i),
    .en_i   (adv),
    .t_i    (t_g_q),
    .v1_i   (v1),
    .v2_i   (v2),
    .d_i    (d),
    .zero_i (zero_q),
    .l_i    (l_q),
    .byte_o (green_o)
  );

  hslrgb_chan u_blue (
    .clk_i  (clk_i),
    .en_i   (adv),
    .t_i    (t_b_q),
    .v1_i   (v1),
    .v2_i   (v2),
    .d_i    (d),
    .zero_i (zero_q),
    .l_i    (l_q),
    .byte_o (blue_o)
  );

endmodule
